FILE: sv/csq_pkg.sv
package csq_pkg;

	// Defaults for the top-level parameters.
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;

	// Widths of the channel fields.
	localparam int ACTION_W = 2;
	localparam int CALLER_W = 8;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_OPEN   = 2'd0,
		ACT_WAIT   = 2'd1,
		ACT_SIGNAL = 2'd2,
		ACT_CLOSE  = 2'd3
	} act_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_CLOSED = 2'd1,
		ST_FULL   = 2'd2
	} status_e;

	// Steps of the control program.
	typedef enum logic [3:0] {
		S_FETCH      = 4'd0,
		S_DECODE     = 4'd1,
		S_OPEN       = 4'd2,
		S_REJECT     = 4'd3,
		S_WAIT       = 4'd4,
		S_WAIT_TAKE  = 4'd5,
		S_WAIT_TEST  = 4'd6,
		S_WAIT_FULL  = 4'd7,
		S_WAIT_PUSH  = 4'd8,
		S_SIGNAL     = 4'd9,
		S_SIG_POP    = 4'd10,
		S_SIG_INC    = 4'd11,
		S_CLOSE      = 4'd12,
		S_CLOSE_POP  = 4'd13,
		S_CLOSE_DONE = 4'd14,
		S_CLOSE_NONE = 4'd15
	} step_e;

	typedef enum logic [1:0] {
		CNT_NONE,
		CNT_LOAD,
		CNT_DEC,
		CNT_INC_SAT
	} cnt_op_e;

	typedef enum logic [1:0] {
		Q_NONE,
		Q_PUSH,
		Q_POP,
		Q_CLEAR
	} q_op_e;

	typedef enum logic [1:0] {
		CLO_NONE,
		CLO_CLEAR,
		CLO_SET
	} clo_op_e;

	typedef enum logic {
		LAST_ONE,
		LAST_OCC_ONE
	} last_sel_e;

	// Jump conditions; when a condition is false the step counter advances by one.
	typedef enum logic [2:0] {
		BR_NEXT,
		BR_ALWAYS,
		BR_NO_ITEM,
		BR_DISPATCH,
		BR_COUNT_ZERO,
		BR_NOT_FULL,
		BR_Q_EMPTY,
		BR_OCC_MORE
	} br_e;

	// One control word of the program.
	typedef struct packed {
		logic      accept;
		logic      emit;
		cnt_op_e   cnt_op;
		q_op_e     q_op;
		clo_op_e   clo_op;
		status_e   status;
		logic      blocked;
		logic      rvalid;
		last_sel_e last_sel;
		br_e       br;
		step_e     target;
	} ctrl_t;

	// Datapath conditions seen by the sequencer.
	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic closed;
		logic count_zero;
		logic q_full;
		logic q_empty;
		logic occ_more;
		act_e act;
	} flags_t;

	localparam ctrl_t CTRL_NOP = '{
		accept:   1'b0,
		emit:     1'b0,
		cnt_op:   CNT_NONE,
		q_op:     Q_NONE,
		clo_op:   CLO_NONE,
		status:   ST_OK,
		blocked:  1'b0,
		rvalid:   1'b0,
		last_sel: LAST_ONE,
		br:       BR_NEXT,
		target:   S_FETCH
	};

	// Control store: one word for each step.
	function automatic ctrl_t ucode_rom(step_e pc);
		ctrl_t w;
		w = CTRL_NOP;
		unique case (pc)
			S_FETCH: begin
				w.accept = 1'b1;
				w.br     = BR_NO_ITEM;
				w.target = S_FETCH;
			end
			S_DECODE: begin
				w.br = BR_DISPATCH;
			end
			S_OPEN: begin
				w.emit   = 1'b1;
				w.cnt_op = CNT_LOAD;
				w.q_op   = Q_CLEAR;
				w.clo_op = CLO_CLEAR;
				w.br     = BR_ALWAYS;
			end
			S_REJECT: begin
				w.emit   = 1'b1;
				w.status = ST_CLOSED;
				w.br     = BR_ALWAYS;
			end
			S_WAIT: begin
				w.br     = BR_COUNT_ZERO;
				w.target = S_WAIT_TEST;
			end
			S_WAIT_TAKE: begin
				w.emit   = 1'b1;
				w.cnt_op = CNT_DEC;
				w.br     = BR_ALWAYS;
			end
			S_WAIT_TEST: begin
				w.br     = BR_NOT_FULL;
				w.target = S_WAIT_PUSH;
			end
			S_WAIT_FULL: begin
				w.emit   = 1'b1;
				w.status = ST_FULL;
				w.br     = BR_ALWAYS;
			end
			S_WAIT_PUSH: begin
				w.emit    = 1'b1;
				w.q_op    = Q_PUSH;
				w.blocked = 1'b1;
				w.br      = BR_ALWAYS;
			end
			S_SIGNAL: begin
				w.br     = BR_Q_EMPTY;
				w.target = S_SIG_INC;
			end
			S_SIG_POP: begin
				w.emit   = 1'b1;
				w.q_op   = Q_POP;
				w.rvalid = 1'b1;
				w.br     = BR_ALWAYS;
			end
			S_SIG_INC: begin
				w.emit   = 1'b1;
				w.cnt_op = CNT_INC_SAT;
				w.br     = BR_ALWAYS;
			end
			S_CLOSE: begin
				w.br     = BR_Q_EMPTY;
				w.target = S_CLOSE_NONE;
			end
			S_CLOSE_POP: begin
				w.emit     = 1'b1;
				w.q_op     = Q_POP;
				w.rvalid   = 1'b1;
				w.last_sel = LAST_OCC_ONE;
				w.br       = BR_OCC_MORE;
				w.target   = S_CLOSE_POP;
			end
			S_CLOSE_DONE: begin
				w.q_op   = Q_CLEAR;
				w.clo_op = CLO_SET;
				w.br     = BR_ALWAYS;
			end
			S_CLOSE_NONE: begin
				w.emit   = 1'b1;
				w.clo_op = CLO_SET;
				w.br     = BR_ALWAYS;
			end
		endcase
		return w;
	endfunction

	// Entry step of the handler for an action.
	function automatic step_e dispatch(act_e a, logic closed);
		step_e s;
		s = S_REJECT;
		priority if (a == ACT_OPEN) begin
			s = S_OPEN;
		end else if (closed) begin
			s = S_REJECT;
		end else if (a == ACT_WAIT) begin
			s = S_WAIT;
		end else if (a == ACT_SIGNAL) begin
			s = S_SIGNAL;
		end else begin
			s = S_CLOSE;
		end
		return s;
	endfunction

endpackage

FILE: sv/csq_if.sv
// Request channel: one action item.
interface csq_req_if;
	import csq_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CALLER_W-1:0] caller_id;
	logic [COUNT_W-1:0]  init_value;

	modport source (output valid, action, caller_id, init_value, input ready);
	modport sink (input valid, action, caller_id, init_value, output ready);
endinterface

// Response channel: one result item.
interface csq_rsp_if;
	import csq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                caller_blocked;
	logic                release_valid;
	logic [CALLER_W-1:0] released_id;
	logic                last;

	modport source (output valid, status, caller_blocked, release_valid, released_id, last,
		input ready);
	modport sink (input valid, status, caller_blocked, release_valid, released_id, last,
		output ready);
endinterface

FILE: sv/counting_semaphore_wait_queue.sv
// Channel  Role    Fields
// req      sink    action, caller_id, init_value
// rsp      source  status, caller_blocked, release_valid, released_id, last
//
// A step counter walks a 16-word control program, one word per cycle while not stalled.
// After fetch and decode, open runs open and an action on a closed semaphore reject; a wait
// runs wait, then wait_take or, at zero count, wait_test and wait_push or wait_full; a signal
// runs signal and sig_pop or sig_inc; close runs close, then close_none with no waiter or
// one close_pop per waiter, one release per cycle if not stalled, then close_done. req.ready
// is high only in fetch; an untaken result in the output register stalls only emitting steps.
// Reset leaves the semaphore closed with an empty queue and no result pending.
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = csq_pkg::ID_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	csq_req_if.sink   req,
	csq_rsp_if.source rsp
);
	import csq_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;
	logic   go;

	// Program sequencer.
	csq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.go     (go)
	);

	// Count, closed flag, wait queue and output register.
	csq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.go     (go),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

FILE: sv/csq_seq.sv
module csq_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  csq_pkg::flags_t flags,
	output csq_pkg::ctrl_t  ctrl,
	output logic            go
);
	import csq_pkg::*;

	step_e pc_q;
	step_e pc_d;
	step_e pc_inc;
	logic  take;

	// Fetch the control word for the current step.
	assign ctrl   = ucode_rom(pc_q);
	assign pc_inc = step_e'(4'(pc_q) + 4'd1);

	// A step that emits a result waits while the output register is full and not taken.
	assign go = !(ctrl.emit && flags.out_busy);

	// Jump condition and next step.
	always_comb begin
		take = 1'b0;
		pc_d = pc_inc;
		unique case (ctrl.br)
			BR_NEXT:       take = 1'b0;
			BR_ALWAYS:     take = 1'b1;
			BR_NO_ITEM:    take = !flags.in_valid;
			BR_COUNT_ZERO: take = flags.count_zero;
			BR_NOT_FULL:   take = !flags.q_full;
			BR_Q_EMPTY:    take = flags.q_empty;
			BR_OCC_MORE:   take = flags.occ_more;
			BR_DISPATCH:   take = 1'b0;
		endcase
		if (!go) begin
			pc_d = pc_q;
		end else if (ctrl.br == BR_DISPATCH) begin
			pc_d = dispatch(flags.act, flags.closed);
		end else if (take) begin
			pc_d = ctrl.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: sv/csq_dp.sv
module csq_dp #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = csq_pkg::ID_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  csq_pkg::ctrl_t  ctrl,
	input  logic            go,
	output csq_pkg::flags_t flags,
	csq_req_if.sink         req,
	csq_rsp_if.source       rsp
);
	import csq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	act_e                act_q;
	logic [ID_WIDTH-1:0] caller_q;
	logic [COUNT_W-1:0]  init_q;
	logic [COUNT_W-1:0]  count_q;
	logic                closed_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [PTR_W-1:0]    head_d;
	logic [OCC_W-1:0]    occ_q;
	logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] rd_q;
	logic                push;
	logic                pop;
	logic                clear;
	logic                out_valid_q;
	logic                load_out;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push     = go && (ctrl.q_op == Q_PUSH);
	assign pop      = go && (ctrl.q_op == Q_POP);
	assign clear    = go && (ctrl.q_op == Q_CLEAR);
	assign load_out = go && ctrl.emit;

	assign req.ready = ctrl.accept;

	// Conditions for the sequencer.
	always_comb begin
		flags.in_valid   = req.valid;
		flags.out_busy   = out_valid_q && !rsp.ready;
		flags.closed     = closed_q;
		flags.count_zero = (count_q == '0);
		flags.q_full     = (occ_q == OCC_W'(QUEUE_DEPTH));
		flags.q_empty    = (occ_q == '0);
		flags.occ_more   = (occ_q > OCC_W'(1));
		flags.act        = act_q;
	end

	// Input item register.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q    <= act_e'(req.action);
			caller_q <= ID_WIDTH'(req.caller_id);
			init_q   <= req.init_value;
		end
	end

	// Count and closed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b1;
		end else if (go) begin
			unique case (ctrl.cnt_op)
				CNT_NONE:    count_q <= count_q;
				CNT_LOAD:    count_q <= init_q;
				CNT_DEC:     count_q <= count_q - 1'b1;
				CNT_INC_SAT: count_q <= (count_q == '1) ? count_q : count_q + 1'b1;
			endcase
			unique case (ctrl.clo_op)
				CLO_NONE:  closed_q <= closed_q;
				CLO_CLEAR: closed_q <= 1'b0;
				CLO_SET:   closed_q <= 1'b1;
				default:   closed_q <= closed_q;
			endcase
		end
	end

	// Ring pointers and occupancy.
	always_comb begin
		head_d = head_q;
		if (clear) begin
			head_d = '0;
		end else if (pop) begin
			head_d = ptr_inc(head_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			head_q <= head_d;
			if (clear) begin
				tail_q <= '0;
				occ_q  <= '0;
			end else if (push) begin
				tail_q <= ptr_inc(tail_q);
				occ_q  <= occ_q + 1'b1;
			end else if (pop) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	// Wait queue memory; the read port follows the next head so rd_q holds the oldest id.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= caller_q;
		end
		if (push && (tail_q == head_d)) begin
			rd_q <= caller_q;
		end else begin
			rd_q <= mem[head_d];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp.status         <= ctrl.status;
			rsp.caller_blocked <= ctrl.blocked;
			rsp.release_valid  <= ctrl.rvalid;
			rsp.released_id    <= ctrl.rvalid ? CALLER_W'(rd_q) : '0;
			rsp.last           <= (ctrl.last_sel == LAST_ONE) || (occ_q == OCC_W'(1));
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

FILE: sv/csq_checker.sv
module csq_checker (
	input logic       clk,
	input logic       arst_n,
	csq_req_if.sink   req,
	csq_rsp_if.source rsp
);
	import csq_pkg::*;

	// A stalled result item keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
			&& $stable(rsp.released_id) && $stable(rsp.release_valid) && $stable(rsp.last))
		else $error("result item changed while stalled");

	// Only a close drain gives results that are not last, and each is a release.
	a_nonlast_release: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.release_valid && (rsp.status == ST_OK)
			&& !rsp.caller_blocked)
		else $error("non-final result is not an ok release");

	// A released id is zero unless a release is reported; blocked excludes release.
	a_id_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (!rsp.release_valid || rsp.caller_blocked)
			|-> (rsp.released_id == '0) && !(rsp.release_valid && rsp.caller_blocked))
		else $error("released id or blocked flag inconsistent");

	// No new action item is taken while a close drain is still in progress.
	a_drain_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> !req.ready)
		else $error("input accepted during close drain");

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

FILE: test/counting_semaphore_wait_queue_test.sv
`timescale 1ns / 100ps

module counting_semaphore_wait_queue_test;
	import csq_pkg::*;

	localparam int QDEPTH         = QUEUE_DEPTH_DEF;
	localparam int IDW            = ID_WIDTH_DEF;
	localparam int RANDOM_ITEMS   = 280;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

	// One result item as the block should produce it.
	typedef struct packed {
		status_e             status;
		logic                blocked;
		logic                rvalid;
		logic [CALLER_W-1:0] rid;
		logic                last;
	} sem_result_t;

	// One action item, with an optional typed-in single result.
	typedef struct packed {
		act_e                action;
		logic [CALLER_W-1:0] caller;
		logic [COUNT_W-1:0]  init;
		logic                typed;
		status_e             exp_status;
		logic                exp_blocked;
	} sem_row_t;

	localparam int NROWS = 27;

	// Directed rows: closed after reset, saturation, the full queue and a draining close.
	sem_row_t directed_rows [NROWS] = '{
		'{ACT_WAIT,   8'h00, 16'h0000, 1'b1, ST_CLOSED, 1'b0},
		'{ACT_SIGNAL, 8'hFF, 16'hFFFF, 1'b1, ST_CLOSED, 1'b0},
		'{ACT_CLOSE,  8'h5A, 16'h0000, 1'b1, ST_CLOSED, 1'b0},
		'{ACT_OPEN,   8'h00, 16'hFFFF, 1'b1, ST_OK,     1'b0},
		'{ACT_SIGNAL, 8'h11, 16'h0000, 1'b1, ST_OK,     1'b0},
		'{ACT_WAIT,   8'h22, 16'h0000, 1'b1, ST_OK,     1'b0},
		'{ACT_CLOSE,  8'h33, 16'h0000, 1'b1, ST_OK,     1'b0},
		'{ACT_OPEN,   8'hFF, 16'h0000, 1'b1, ST_OK,     1'b0},
		'{ACT_WAIT,   8'hFF, 16'hFFFF, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h00, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h01, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h02, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h04, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h08, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h10, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h20, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h40, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h80, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'hFE, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h7F, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'hA5, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h5A, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'hC3, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h3C, 16'h0000, 1'b1, ST_OK,     1'b1},
		'{ACT_WAIT,   8'h99, 16'h0000, 1'b1, ST_FULL,   1'b0},
		'{ACT_SIGNAL, 8'h12, 16'h0000, 1'b0, ST_OK,     1'b0},
		'{ACT_CLOSE,  8'h34, 16'h0000, 1'b0, ST_OK,     1'b0}
	};

	logic clk;
	logic arst_n;

	csq_req_if req_ch ();
	csq_rsp_if rsp_ch ();

	counting_semaphore_wait_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow state of the semaphore.
	logic [COUNT_W-1:0]  sem_count;
	logic                sem_closed;
	logic [CALLER_W-1:0] blocked_ids [$];

	sem_result_t expected_results [$];
	sem_row_t    row_on_bus;
	bit          no_idle;
	int          mismatches;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Result item built from the given field values.
	function automatic sem_result_t plain_result(status_e st, logic blk, logic rv,
		logic [CALLER_W-1:0] id, logic lst);
		sem_result_t r;
		r.status  = st;
		r.blocked = blk;
		r.rvalid  = rv;
		r.rid     = id;
		r.last    = lst;
		return r;
	endfunction

	// Applies one action to the shadow state and returns the results it causes.
	function automatic void predict_action(input act_e a, input logic [CALLER_W-1:0] caller,
		input logic [COUNT_W-1:0] init, output sem_result_t outs [$]);
		logic [CALLER_W-1:0] id;
		logic [CALLER_W-1:0] kept;
		outs = {};
		kept = caller & CALLER_W'((1 << IDW) - 1);
		if (a == ACT_OPEN) begin
			sem_count   = init;
			sem_closed  = 1'b0;
			blocked_ids = {};
			outs.push_back(plain_result(ST_OK, 1'b0, 1'b0, '0, 1'b1));
		end else if (sem_closed) begin
			outs.push_back(plain_result(ST_CLOSED, 1'b0, 1'b0, '0, 1'b1));
		end else if (a == ACT_WAIT) begin
			if (sem_count != '0) begin
				sem_count = sem_count - 1'b1;
				outs.push_back(plain_result(ST_OK, 1'b0, 1'b0, '0, 1'b1));
			end else if (blocked_ids.size() >= QDEPTH) begin
				outs.push_back(plain_result(ST_FULL, 1'b0, 1'b0, '0, 1'b1));
			end else begin
				blocked_ids.push_back(kept);
				outs.push_back(plain_result(ST_OK, 1'b1, 1'b0, '0, 1'b1));
			end
		end else if (a == ACT_SIGNAL) begin
			if (blocked_ids.size() > 0) begin
				id = blocked_ids.pop_front();
				outs.push_back(plain_result(ST_OK, 1'b0, 1'b1, id, 1'b1));
			end else begin
				if (sem_count != COUNT_TOP) begin
					sem_count = sem_count + 1'b1;
				end
				outs.push_back(plain_result(ST_OK, 1'b0, 1'b0, '0, 1'b1));
			end
		end else begin
			// Close releases every waiter, oldest first, then locks the semaphore.
			if (blocked_ids.size() == 0) begin
				outs.push_back(plain_result(ST_OK, 1'b0, 1'b0, '0, 1'b1));
			end
			while (blocked_ids.size() > 0) begin
				id = blocked_ids.pop_front();
				outs.push_back(plain_result(ST_OK, 1'b0, 1'b1, id, blocked_ids.size() == 0));
			end
			sem_closed = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Presents one item, with random idle cycles ahead of it, and waits for its acceptance.
	task automatic send_action(input sem_row_t row);
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			req_ch.valid      <= 1'b0;
			req_ch.action     <= ACTION_W'($urandom_range(0, 3));
			req_ch.caller_id  <= CALLER_W'($urandom_range(0, 255));
			@(negedge clk);
		end
		row_on_bus        <= row;
		req_ch.valid      <= 1'b1;
		req_ch.action     <= row.action;
		req_ch.caller_id  <= row.caller;
		req_ch.init_value <= row.init;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Receiver: stalls at random except during the quiet stretch.
	always @(negedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
	end

	// Acceptance of actions, checking of results, and the watchdog.
	always @(posedge clk) begin
		sem_result_t fresh [$];
		sem_result_t got;
		sem_result_t want;
		bit          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				moved = 1'b1;
				predict_action(act_e'(req_ch.action), req_ch.caller_id, req_ch.init_value,
					fresh);
				if (row_on_bus.typed) begin
					expected_results.push_back(plain_result(row_on_bus.exp_status,
						row_on_bus.exp_blocked, 1'b0, '0, 1'b1));
				end else begin
					foreach (fresh[i]) begin
						expected_results.push_back(fresh[i]);
					end
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved       = 1'b1;
				got.status  = status_e'(rsp_ch.status);
				got.blocked = rsp_ch.caller_blocked;
				got.rvalid  = rsp_ch.release_valid;
				got.rid     = rsp_ch.released_id;
				got.last    = rsp_ch.last;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %p", got));
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.blocked !== want.blocked ||
						got.rvalid !== want.rvalid || got.rid !== want.rid ||
						got.last !== want.last) begin
						report_mismatch($sformatf(
							"status %0d/%0d blocked %b/%b release %b/%b id %h/%h last %b/%b",
							got.status, want.status, got.blocked, want.blocked,
							got.rvalid, want.rvalid, got.rid, want.rid, got.last, want.last));
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Stimulus: reset, the directed table, then random traffic in sessions.
	initial begin
		sem_row_t row;
		int       mode;
		int       wait_pct;
		int       sig_pct;
		int       pick;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_OPEN;
		req_ch.caller_id  = '0;
		req_ch.init_value = '0;
		rsp_ch.ready      = 1'b0;
		row_on_bus        = '0;
		no_idle           = 1'b0;
		mismatches        = 0;
		quiet_cycles      = 0;
		sem_count         = '0;
		sem_closed        = 1'b1;
		blocked_ids       = {};
		mode              = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NROWS; i++) begin
			send_action(directed_rows[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Halfway through, hold off until every result is back.
			if (n == RANDOM_ITEMS / 2) begin
				req_ch.valid <= 1'b0;
				wait (expected_results.size() == 0);
				@(negedge clk);
			end
			no_idle = (n >= 40 && n < 110);
			row     = '0;
			pick    = $urandom_range(0, 99);
			case (mode)
				1: begin
					wait_pct = 72;
					sig_pct  = 18;
				end
				2: begin
					wait_pct = 25;
					sig_pct  = 65;
				end
				default: begin
					wait_pct = 45;
					sig_pct  = 43;
				end
			endcase
			if (sem_closed) begin
				row.action = (pick < 80) ? ACT_OPEN : act_e'($urandom_range(1, 3));
			end else if (pick < 4) begin
				row.action = ACT_OPEN;
			end else if (pick < 4 + wait_pct) begin
				row.action = ACT_WAIT;
			end else if (pick < 4 + wait_pct + sig_pct) begin
				row.action = ACT_SIGNAL;
			end else begin
				row.action = ACT_CLOSE;
			end
			row.caller = CALLER_W'($urandom_range(0, 255));
			pick       = $urandom_range(0, 9);
			if (pick < 6) begin
				row.init = COUNT_W'($urandom_range(0, 3));
			end else if (pick == 6) begin
				row.init = COUNT_TOP;
			end else if (pick == 7) begin
				row.init = COUNT_TOP - 1'b1;
			end else begin
				row.init = COUNT_W'($urandom_range(0, 65535));
			end
			// Each open starts a session that leans toward waits, signals or neither.
			if (row.action == ACT_OPEN) begin
				mode = $urandom_range(0, 2);
			end
			send_action(row);
		end

		req_ch.valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
